FILE: rtl/core/affine_matrix_multiply_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the affine matrix multiply core
// Shared property forms, clocked on clk and disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef AFFINE_MATRIX_MULTIPLY_CORE_DEFINES_SVH
`define AFFINE_MATRIX_MULTIPLY_CORE_DEFINES_SVH

// Same-cycle implication.
`define AMM_ASSERT_NOW(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |-> (effect)) \
    else $error("amm: same-cycle check failed");

// Next-cycle implication.
`define AMM_ASSERT_NEXT(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error("amm: next-cycle check failed");

`endif

FILE: rtl/core/amm_pkg.sv
// ---------------------------------------------------------------------------
// amm_pkg
// Types and codes shared by the affine matrix multiply core.
// ---------------------------------------------------------------------------
package amm_pkg;

  localparam int ROWS      = 4;
  localparam int COLS      = 3;
  localparam int Q_W       = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * Q_W;
  localparam int SHP_W     = PROD_W - FRAC_BITS;
  localparam int SUM_W     = SHP_W + 2;

  localparam logic       OP_LOAD = 1'b0;
  localparam logic       OP_MUL  = 1'b1;
  localparam logic [1:0] ROW_POS = 2'd3;

  localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef struct packed {
    logic                  op;
    logic [1:0]            row_index;
    logic signed [Q_W-1:0] in_x;
    logic signed [Q_W-1:0] in_y;
    logic signed [Q_W-1:0] in_z;
  } req_t;

  typedef struct packed {
    logic [1:0]            out_row;
    logic signed [Q_W-1:0] out_x;
    logic signed [Q_W-1:0] out_y;
    logic signed [Q_W-1:0] out_z;
    logic                  overflow;
  } rsp_t;

  // Row of B, component 0 is x.
  typedef logic [COLS-1:0][Q_W-1:0] b_row_t;
  typedef b_row_t [ROWS-1:0]        b_mat_t;

  typedef struct packed {
    logic load;
    logic valid;
  } stage_ctl_t;

  typedef struct packed {
    logic [1:0]                        row;
    b_row_t                            pos;
    logic [COLS*COLS-1:0][PROD_W-1:0]  prod;
  } mul_t;

  typedef struct packed {
    logic [1:0]                  row;
    logic [COLS-1:0][SUM_W-1:0]  sum;
  } acc_t;

endpackage

FILE: rtl/core/amm_bank.sv
// ---------------------------------------------------------------------------
// amm_bank
// Register file holding the four rows of matrix B.
// ---------------------------------------------------------------------------
module amm_bank (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [1:0]      wr_row,
  input  amm_pkg::b_row_t wr_data,
  output amm_pkg::b_mat_t bmat
);

  amm_pkg::b_mat_t mem;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
  end

  assign bmat = mem;

endmodule

FILE: rtl/core/amm_mul.sv
// ---------------------------------------------------------------------------
// amm_mul
// First stage: nine 32x32 signed products of the A row against B.
// ---------------------------------------------------------------------------
module amm_mul (
  input  logic                clk,
  input  logic                rst,
  input  amm_pkg::stage_ctl_t ctl,
  input  amm_pkg::req_t       req,
  input  amm_pkg::b_mat_t     bmat,
  output logic                valid,
  output amm_pkg::mul_t       data
);

  amm_pkg::mul_t         data_next;
  logic [amm_pkg::Q_W-1:0] a [amm_pkg::COLS];

  always_comb begin
    a[0] = req.in_x;
    a[1] = req.in_y;
    a[2] = req.in_z;
    data_next.row = req.row_index;
    data_next.pos = bmat[amm_pkg::ROW_POS];
    for (int k = 0; k < amm_pkg::COLS; k++) begin
      for (int c = 0; c < amm_pkg::COLS; c++) begin
        // Sign-extend both factors so the full product is kept.
        data_next.prod[k*amm_pkg::COLS+c] =
          64'($signed(a[k])) * 64'($signed(bmat[k][c]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.load) begin
      valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= data_next;
    end
  end

endmodule

FILE: rtl/core/amm_acc.sv
// ---------------------------------------------------------------------------
// amm_acc
// Second stage: drop each product's fraction, sum per component, add position on row 3.
// ---------------------------------------------------------------------------
module amm_acc (
  input  logic                clk,
  input  logic                rst,
  input  amm_pkg::stage_ctl_t ctl,
  input  amm_pkg::mul_t       mul,
  output logic                valid,
  output amm_pkg::acc_t       data
);

  amm_pkg::acc_t data_next;
  logic signed [amm_pkg::SUM_W-1:0] term;
  logic signed [amm_pkg::SUM_W-1:0] total;

  always_comb begin
    data_next.row = mul.row;
    term  = '0;
    total = '0;
    for (int c = 0; c < amm_pkg::COLS; c++) begin
      // Position row adds B's position entry as is.
      if (mul.row == amm_pkg::ROW_POS) begin
        total = $signed({{(amm_pkg::SUM_W-amm_pkg::Q_W){mul.pos[c][amm_pkg::Q_W-1]}},
                         mul.pos[c]});
      end else begin
        total = '0;
      end
      for (int k = 0; k < amm_pkg::COLS; k++) begin
        // Keep the high bits: arithmetic shift right by the fraction width.
        term = $signed({{(amm_pkg::SUM_W-amm_pkg::SHP_W)
                         {mul.prod[k*amm_pkg::COLS+c][amm_pkg::PROD_W-1]}},
                        mul.prod[k*amm_pkg::COLS+c][amm_pkg::PROD_W-1:amm_pkg::FRAC_BITS]});
        total = total + term;
      end
      data_next.sum[c] = total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.load) begin
      valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= data_next;
    end
  end

endmodule

FILE: rtl/core/amm_sat.sv
// ---------------------------------------------------------------------------
// amm_sat
// Last stage: clamp each sum to 32 bits and hold the result item.
// ---------------------------------------------------------------------------
module amm_sat (
  input  logic                clk,
  input  logic                rst,
  input  amm_pkg::stage_ctl_t ctl,
  input  amm_pkg::acc_t       acc,
  output logic                valid,
  output amm_pkg::rsp_t       data
);

  amm_pkg::rsp_t data_next;
  logic [amm_pkg::COLS-1:0][amm_pkg::Q_W-1:0] clamped;
  logic [amm_pkg::COLS-1:0] ovf;
  logic [amm_pkg::SUM_W-amm_pkg::Q_W:0] top;

  always_comb begin
    top = '0;
    for (int c = 0; c < amm_pkg::COLS; c++) begin
      top = acc.sum[c][amm_pkg::SUM_W-1:amm_pkg::Q_W-1];
      // Fits when all bits above the result sign agree with it.
      if ((top == '0) || (top == '1)) begin
        ovf[c]     = 1'b0;
        clamped[c] = acc.sum[c][amm_pkg::Q_W-1:0];
      end else begin
        ovf[c]     = 1'b1;
        clamped[c] = acc.sum[c][amm_pkg::SUM_W-1] ? amm_pkg::Q_MIN : amm_pkg::Q_MAX;
      end
    end
    data_next.out_row  = acc.row;
    data_next.out_x    = clamped[0];
    data_next.out_y    = clamped[1];
    data_next.out_z    = clamped[2];
    data_next.overflow = |ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.load) begin
      valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= data_next;
    end
  end

endmodule

FILE: rtl/core/affine_matrix_multiply_core.sv
// Path: a multiply item is registered in the multiply, sum and clamp stages in turn.
// Throughput: one item per cycle, loads and multiplies alike, set by the three-stage
//   pipeline (multiply, shift and sum, clamp) that advances every unstalled cycle.
// Reset: rst is synchronous and active high; it clears the stage valid bits only.
//   Matrix B holds no reset value and must be loaded before its rows are used.
// ---------------------------------------------------------------------------
// affine_matrix_multiply_core
// Row-by-row product of two 4x3 affine matrices in signed Q16.16.
// ---------------------------------------------------------------------------
`include "affine_matrix_multiply_core_defines.svh"

module affine_matrix_multiply_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  amm_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output amm_pkg::rsp_t rsp
);

  // Stage valid bits and payloads.
  logic          mul_valid;
  logic          acc_valid;
  amm_pkg::mul_t mul_data;
  amm_pkg::acc_t acc_data;

  // Per-stage load enables: a stage takes new data when it is empty or
  // when the stage after it moves on in the same cycle.
  logic mul_ready;
  logic acc_ready;
  logic sat_ready;

  amm_pkg::stage_ctl_t mul_ctl;
  amm_pkg::stage_ctl_t acc_ctl;
  amm_pkg::stage_ctl_t sat_ctl;

  logic            req_take;
  logic            load_take;
  amm_pkg::b_mat_t bmat;

  assign sat_ready = !rsp_valid || !rsp_stall;
  assign acc_ready = !acc_valid || sat_ready;
  assign mul_ready = !mul_valid || acc_ready;

  // Hold the input whenever the first stage cannot advance.
  assign req_stall = !mul_ready;
  assign req_take  = req_valid && mul_ready;
  assign load_take = req_take && (req.op == amm_pkg::OP_LOAD);

  // Loads write B at the accepting edge; they enter no stage. A multiply that
  // follows a load in the next cycle already sees the new row.
  amm_bank u_bank (
    .clk     (clk),
    .wr_en   (load_take),
    .wr_row  (req.row_index),
    .wr_data ({req.in_z, req.in_y, req.in_x}),
    .bmat    (bmat)
  );

  // Only multiply items carry a valid bit down the pipeline.
  assign mul_ctl = '{load: mul_ready, valid: req_take && (req.op == amm_pkg::OP_MUL)};
  assign acc_ctl = '{load: acc_ready, valid: mul_valid};
  assign sat_ctl = '{load: sat_ready, valid: acc_valid};

  amm_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mul_ctl),
    .req   (req),
    .bmat  (bmat),
    .valid (mul_valid),
    .data  (mul_data)
  );

  amm_acc u_acc (
    .clk   (clk),
    .rst   (rst),
    .ctl   (acc_ctl),
    .mul   (mul_data),
    .valid (acc_valid),
    .data  (acc_data)
  );

  // Output register doubles as the last stage.
  amm_sat u_sat (
    .clk   (clk),
    .rst   (rst),
    .ctl   (sat_ctl),
    .acc   (acc_data),
    .valid (rsp_valid),
    .data  (rsp)
  );

  // A fully occupied, stalled pipeline must push back on the input.
  `AMM_ASSERT_NOW(a_full_stall, rsp_valid && rsp_stall && acc_valid && mul_valid, req_stall)

  // A taken result with nothing behind it leaves the output empty.
  `AMM_ASSERT_NEXT(a_drain, rsp_valid && !rsp_stall && !acc_valid, !rsp_valid)

  // A load lands in its B row at the accepting edge.
  `AMM_ASSERT_NEXT(a_load_x, load_take, bmat[$past(req.row_index)][0] == $past(req.in_x))

endmodule

FILE: tb/affine_matrix_multiply_core_tb.sv
// ---------------------------------------------------------------------------
// affine_matrix_multiply_core_tb
// Self-checking bench for the affine row product core. It loads rows of B,
// streams multiply items, predicts each product row in Q16.16 with
// saturation, and checks every result in order under varying
// sender idle and receiver stall patterns.
// ---------------------------------------------------------------------------
module affine_matrix_multiply_core_tb;

  localparam logic signed [amm_pkg::Q_W-1:0] ONE     = 32'sh0001_0000;
  localparam logic signed [amm_pkg::Q_W-1:0] NEG_ONE = -32'sh0001_0000;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam int PHASES = 5;
  localparam int ITEMS_PER_PHASE = 360;

  // Keep a private copy of B and the queue of product rows still to come.
  class affine_row_checker;
    logic signed [amm_pkg::Q_W-1:0] b_rows [amm_pkg::ROWS][amm_pkg::COLS];
    amm_pkg::rsp_t expected_rows[$];
    int mismatch_count;

    function new();
      mismatch_count = 0;
      foreach (b_rows[r, c]) b_rows[r][c] = '0;
    endfunction

    task report(string what);
      $display("MISMATCH %0t: %s", $time, what);
      mismatch_count++;
    endtask

    // Weight B's direction rows by the A row, add the position row on row 3,
    // then clamp each component once.
    function amm_pkg::rsp_t product_row(amm_pkg::req_t item);
      logic signed [amm_pkg::Q_W-1:0] a [amm_pkg::COLS];
      longint sum;
      amm_pkg::rsp_t p;
      a[0] = item.in_x;
      a[1] = item.in_y;
      a[2] = item.in_z;
      p = '0;
      p.out_row = item.row_index;
      for (int c = 0; c < amm_pkg::COLS; c++) begin
        sum = 0;
        for (int k = 0; k < amm_pkg::COLS; k++)
          sum += (longint'(a[k]) * longint'(b_rows[k][c])) >>> amm_pkg::FRAC_BITS;
        if (item.row_index == amm_pkg::ROW_POS) sum += longint'(b_rows[amm_pkg::ROW_POS][c]);
        if (sum > SAT_HI) begin
          sum = SAT_HI;
          p.overflow = 1'b1;
        end else if (sum < SAT_LO) begin
          sum = SAT_LO;
          p.overflow = 1'b1;
        end
        case (c)
          0: p.out_x = 32'(sum);
          1: p.out_y = 32'(sum);
          default: p.out_z = 32'(sum);
        endcase
      end
      return p;
    endfunction

    function void note_item(amm_pkg::req_t item);
      if (item.op == amm_pkg::OP_LOAD) begin
        b_rows[item.row_index][0] = item.in_x;
        b_rows[item.row_index][1] = item.in_y;
        b_rows[item.row_index][2] = item.in_z;
      end else begin
        expected_rows.push_back(product_row(item));
      end
    endfunction

    task check_row(amm_pkg::rsp_t got);
      amm_pkg::rsp_t want;
      if (expected_rows.size() == 0) begin
        report($sformatf("result row %0d with no multiply item pending", got.out_row));
        return;
      end
      want = expected_rows.pop_front();
      if (got.out_row !== want.out_row)
        report($sformatf("out_row got %0d want %0d", got.out_row, want.out_row));
      if (got.out_x !== want.out_x)
        report($sformatf("row %0d out_x got %h want %h", want.out_row, got.out_x, want.out_x));
      if (got.out_y !== want.out_y)
        report($sformatf("row %0d out_y got %h want %h", want.out_row, got.out_y, want.out_y));
      if (got.out_z !== want.out_z)
        report($sformatf("row %0d out_z got %h want %h", want.out_row, got.out_z, want.out_z));
      if (got.overflow !== want.overflow)
        report($sformatf("row %0d overflow got %b want %b", want.out_row, got.overflow,
                         want.overflow));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  amm_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  amm_pkg::rsp_t rsp;

  // Percent chance per cycle that the sender idles / the receiver stalls.
  int idle_pct = 0;
  int stall_pct = 0;
  int idle_by_phase  [PHASES] = '{0, 86, 0, 38, 0};
  int stall_by_phase [PHASES] = '{0, 0, 86, 38, 0};

  affine_row_checker board;

  affine_matrix_multiply_core uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #10 clk = ~clk;

  // Draw the receiver stall fresh every cycle.
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  // Sample both handshakes at the edge, before any update of this step lands.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) board.note_item(req);
      if (rsp_valid && !rsp_stall) board.check_row(rsp);
    end
  end

  function amm_pkg::req_t make_item(logic op, logic [1:0] row,
                                    logic signed [amm_pkg::Q_W-1:0] x,
                                    logic signed [amm_pkg::Q_W-1:0] y,
                                    logic signed [amm_pkg::Q_W-1:0] z);
    amm_pkg::req_t item;
    item.op = op;
    item.row_index = row;
    item.in_x = x;
    item.in_y = y;
    item.in_z = z;
    return item;
  endfunction

  // Favor values near unity so sums mostly stay in range, but keep
  // full-width words and the extremes in the mix for saturation.
  function logic signed [amm_pkg::Q_W-1:0] rand_q();
    case ($urandom_range(9))
      0, 1, 2, 3: return $signed($urandom_range(32'h7_FFFF)) - 32'sh4_0000;
      4, 5:       return $signed($urandom_range(32'hFF_FFFF)) - 32'sh80_0000;
      6, 7:       return $urandom();
      default: begin
        case ($urandom_range(6))
          0: return amm_pkg::Q_MAX;
          1: return amm_pkg::Q_MIN;
          2: return '0;
          3: return -1;
          4: return 1;
          5: return ONE;
          default: return NEG_ONE;
        endcase
      end
    endcase
  endfunction

  function amm_pkg::req_t random_item();
    return make_item(($urandom_range(99) < 20) ? amm_pkg::OP_LOAD : amm_pkg::OP_MUL,
                     2'($urandom_range(3)), rand_q(), rand_q(), rand_q());
  endfunction

  // Idle per the sender setting, then hold the item until it is taken.
  task send_item(amm_pkg::req_t item);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  task run_directed();
    // Identity rotation with a translation: row 3 alone picks up the offset.
    send_item(make_item(amm_pkg::OP_LOAD, 2'd0, ONE, '0, '0));
    send_item(make_item(amm_pkg::OP_LOAD, 2'd1, '0, ONE, '0));
    send_item(make_item(amm_pkg::OP_LOAD, 2'd2, '0, '0, ONE));
    send_item(make_item(amm_pkg::OP_LOAD, amm_pkg::ROW_POS, 32'sh5_0000, -32'sh3_0000,
                        32'sh0_4000));
    send_item(make_item(amm_pkg::OP_MUL, 2'd0, 32'sh2_8000, NEG_ONE, 32'sh0_8000));
    send_item(make_item(amm_pkg::OP_MUL, amm_pkg::ROW_POS, 32'sh2_8000, NEG_ONE,
                        32'sh0_8000));
    // Saturate high on x, then low on y through the translation.
    send_item(make_item(amm_pkg::OP_MUL, amm_pkg::ROW_POS, amm_pkg::Q_MAX, amm_pkg::Q_MAX,
                        amm_pkg::Q_MAX));
    send_item(make_item(amm_pkg::OP_MUL, amm_pkg::ROW_POS, amm_pkg::Q_MIN, amm_pkg::Q_MIN,
                        amm_pkg::Q_MIN));
    // Extreme B entries: partial sums leave the 32-bit range but some
    // totals come back inside it.
    send_item(make_item(amm_pkg::OP_LOAD, 2'd0, amm_pkg::Q_MAX, 1, -1));
    send_item(make_item(amm_pkg::OP_LOAD, 2'd1, amm_pkg::Q_MAX, amm_pkg::Q_MIN, 1));
    send_item(make_item(amm_pkg::OP_LOAD, 2'd2, amm_pkg::Q_MIN, -1, amm_pkg::Q_MIN));
    send_item(make_item(amm_pkg::OP_LOAD, amm_pkg::ROW_POS, amm_pkg::Q_MAX, amm_pkg::Q_MIN,
                        '0));
    send_item(make_item(amm_pkg::OP_MUL, 2'd0, ONE, ONE, ONE));
    send_item(make_item(amm_pkg::OP_MUL, amm_pkg::ROW_POS, '0, '0, '0));
    send_item(make_item(amm_pkg::OP_MUL, 2'd0, '0, '0, '0));
    send_item(make_item(amm_pkg::OP_MUL, amm_pkg::ROW_POS, ONE, '0, '0));
    // Tiny negative products round toward minus infinity.
    send_item(make_item(amm_pkg::OP_MUL, 2'd1, -1, -1, -1));
    send_item(make_item(amm_pkg::OP_MUL, 2'd2, amm_pkg::Q_MAX, amm_pkg::Q_MIN,
                        amm_pkg::Q_MIN));
    send_item(make_item(amm_pkg::OP_MUL, amm_pkg::ROW_POS, amm_pkg::Q_MIN, amm_pkg::Q_MIN,
                        amm_pkg::Q_MIN));
  endtask

  // Hard stop far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("affine_matrix_multiply_core verification failed");
    $finish;
  end

  initial begin
    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every B row is written here first, so no later product reads an unset entry.
    run_directed();

    for (int ph = 0; ph < PHASES; ph++) begin
      idle_pct = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      repeat (ITEMS_PER_PHASE) send_item(random_item());
    end
    req_valid <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;

    // Drain the pipeline, then keep running so that any stray result shows.
    while (board.expected_rows.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (board.mismatch_count == 0) begin
      $display("affine_matrix_multiply_core verification clean");
    end else begin
      $display("affine_matrix_multiply_core verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/amm_pkg.sv
rtl/core/amm_bank.sv
rtl/core/amm_mul.sv
rtl/core/amm_acc.sv
rtl/core/amm_sat.sv
rtl/core/affine_matrix_multiply_core.sv
tb/affine_matrix_multiply_core_tb.sv
